[hw/rtl/grbf_pkg.sv]
// Shared types, constants and the exp bit-weight table for the Gaussian RBF grid evaluator.
package grbf_pkg;

	localparam int MAX_CENTERS  = 64;
	localparam int WEIGHT_DEPTH = 1024;
	localparam int LEVELS       = 3;

	localparam int CIDX_W  = $clog2(MAX_CENTERS);
	localparam int CRNG_W  = CIDX_W + 1;
	localparam int WIDX_W  = $clog2(WEIGHT_DEPTH);
	localparam int LVL_W   = 2;
	localparam int SIZE_W  = 11;
	localparam int INV_W   = 24;
	localparam int COORD_W = 17;
	localparam int WGT_W   = 32;
	localparam int SUM_W   = 48;
	localparam int DIV_N_W = 27;
	localparam int DIV_D_W = SIZE_W + 1;
	localparam int EXP_STEPS = 20;
	localparam int IN_DATA_W  = 104;
	localparam int OUT_DATA_W = 48;
	localparam int CFG_ADDR_W = 3;

	typedef enum logic [1:0] {
		KIND_CENTER = 2'd0,
		KIND_WEIGHT = 2'd1,
		KIND_QUERY  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_GRID_X   = 3'd0,
		REG_GRID_Y   = 3'd1,
		REG_WEIGHT_X = 3'd2,
		REG_WEIGHT_Y = 3'd3,
		REG_INV_SIG  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [SIZE_W-1:0] grid_x_size;
		logic [SIZE_W-1:0] grid_y_size;
		logic [SIZE_W-1:0] weight_x_size;
		logic [SIZE_W-1:0] weight_y_size;
		logic [INV_W-1:0]  inv_sigma_sq;
	} cfg_t;

	// packed so that bit 0 of the struct is bit 0 of tdata
	typedef struct packed {
		logic [9:0]         point_y;
		logic [9:0]         point_x;
		logic [WGT_W-1:0]   weight_value;
		logic [LVL_W-1:0]   level_z;
		logic [COORD_W-1:0] center_y;
		logic [COORD_W-1:0] center_x;
		logic [9:0]         slot_index;
	} item_t;

	typedef struct packed {
		logic accept;
		logic start;
		logic div_step;
		logic cen_rd;
		logic sub;
		logic sq;
		logic sum;
		logic mul;
		logic idx;
		logic exp_step;
		logic gmul;
		logic acc;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic empty;
		logic exp_done;
		logic last_center;
	} sts_t;

	// round(2^30 * exp(-2^(b-16)))
	function automatic logic [29:0] exp_bit(input logic [4:0] b);
		logic [29:0] k;
		unique case (b)
			5'd0:  k = 30'd1073725440;
			5'd1:  k = 30'd1073709056;
			5'd2:  k = 30'd1073676290;
			5'd3:  k = 30'd1073610760;
			5'd4:  k = 30'd1073479712;
			5'd5:  k = 30'd1073217664;
			5'd6:  k = 30'd1072693760;
			5'd7:  k = 30'd1071646719;
			5'd8:  k = 30'd1069555701;
			5'd9:  k = 30'd1065385899;
			5'd10: k = 30'd1057095000;
			5'd11: k = 30'd1040706261;
			5'd12: k = 30'd1008687096;
			5'd13: k = 30'd947573834;
			5'd14: k = 30'd836230973;
			5'd15: k = 30'd651257337;
			5'd16: k = 30'd395007542;
			5'd17: k = 30'd145315154;
			5'd18: k = 30'd19666268;
			5'd19: k = 30'd360200;
			default: k = 30'd0;
		endcase
		return k;
	endfunction

endpackage

[hw/rtl/grbf_ctrl.sv]
// Sequencer: accepts beats, steps the datapath through divide, per-center and output phases.
module grbf_ctrl
	import grbf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_is_query,
	input  sts_t sts,
	input  logic out_free,
	output logic in_ready,
	output cmd_t cmd
);

	typedef enum logic [11:0] {
		ST_IDLE = 12'b0000_0000_0001,
		ST_DIV  = 12'b0000_0000_0010,
		ST_CRD  = 12'b0000_0000_0100,
		ST_CSUB = 12'b0000_0000_1000,
		ST_SQ   = 12'b0000_0001_0000,
		ST_SUM  = 12'b0000_0010_0000,
		ST_MUL  = 12'b0000_0100_0000,
		ST_IDX  = 12'b0000_1000_0000,
		ST_EXP  = 12'b0001_0000_0000,
		ST_GMUL = 12'b0010_0000_0000,
		ST_ACC  = 12'b0100_0000_0000,
		ST_DONE = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && in_is_query) begin
					cmd.start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = sts.empty ? ST_DONE : ST_CRD;
				end
			end
			ST_CRD: begin
				cmd.cen_rd = 1'b1;
				state_d    = ST_CSUB;
			end
			ST_CSUB: begin
				cmd.sub = 1'b1;
				state_d = ST_SQ;
			end
			ST_SQ: begin
				cmd.sq  = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_IDX;
			end
			ST_IDX: begin
				cmd.idx = 1'b1;
				state_d = ST_EXP;
			end
			ST_EXP: begin
				cmd.exp_step = 1'b1;
				if (sts.exp_done) begin
					state_d = ST_GMUL;
				end
			end
			ST_GMUL: begin
				cmd.gmul = 1'b1;
				state_d  = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.last_center ? ST_DONE : ST_CRD;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hw/rtl/grbf_dpath.sv]
// Datapath: center/weight stores, level ranges, query coordinate divider and term arithmetic.
module grbf_dpath
	import grbf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  kind_t            kind,
	input  item_t            item,
	input  cfg_t             cfg,
	output sts_t             sts,
	output logic [SUM_W-1:0] res_sum,
	output logic             res_fault
);

	// level ranges
	logic [CRNG_W-1:0] lvl_first_q [LEVELS];
	logic [CRNG_W-1:0] lvl_last_q  [LEVELS];

	logic             lz_ok;
	logic [LVL_W-1:0] lz_sel;
	logic             slot_ok;

	assign lz_ok   = (int'(item.level_z) < LEVELS);
	assign lz_sel  = lz_ok ? item.level_z : '0;
	assign slot_ok = (int'(item.slot_index) < MAX_CENTERS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LEVELS; l++) begin
				lvl_first_q[l] <= CRNG_W'(MAX_CENTERS);
				lvl_last_q[l]  <= '0;
			end
		end else if (cmd.accept && kind == KIND_CENTER && slot_ok && lz_ok) begin
			lvl_last_q[lz_sel] <= CRNG_W'(item.slot_index);
			if (lvl_first_q[lz_sel] > CRNG_W'(item.slot_index)) begin
				lvl_first_q[lz_sel] <= CRNG_W'(item.slot_index);
			end
		end
	end

	// stores
	logic [2*COORD_W-1:0] cen_mem [MAX_CENTERS];
	logic [WGT_W-1:0]     wgt_mem [WEIGHT_DEPTH];
	logic [2*COORD_W-1:0] cen_rd_q;
	logic [WGT_W-1:0]     wgt_rd_q;
	logic [CIDX_W-1:0]    ctr_q;
	logic [24:0]          idx_c;
	logic                 idx_flt;

	always_ff @(posedge clk) begin
		if (cmd.accept && kind == KIND_CENTER && slot_ok && lz_ok) begin
			cen_mem[item.slot_index[CIDX_W-1:0]] <= {item.center_y, item.center_x};
		end
		if (cmd.cen_rd) begin
			cen_rd_q <= cen_mem[ctr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && kind == KIND_WEIGHT && int'(item.slot_index) < WEIGHT_DEPTH) begin
			wgt_mem[item.slot_index[WIDX_W-1:0]] <= item.weight_value;
		end
		if (cmd.idx && !idx_flt) begin
			wgt_rd_q <= wgt_mem[idx_c[WIDX_W-1:0]];
		end
	end

	// sizes with zero treated as one
	logic [SIZE_W-1:0] gx, gy, wx, wy;
	assign gx = (cfg.grid_x_size == '0)   ? SIZE_W'(1) : cfg.grid_x_size;
	assign gy = (cfg.grid_y_size == '0)   ? SIZE_W'(1) : cfg.grid_y_size;
	assign wx = (cfg.weight_x_size == '0) ? SIZE_W'(1) : cfg.weight_x_size;
	assign wy = (cfg.weight_y_size == '0) ? SIZE_W'(1) : cfg.weight_y_size;

	// query setup and two-lane restoring divider, one quotient bit per cycle
	logic [LVL_W-1:0]   lz_q;
	logic               empty_q;
	logic [CIDX_W-1:0]  last_q;
	logic [21:0]        wxy_q;
	logic [DIV_N_W-1:0] num_q [2];
	logic [DIV_D_W-1:0] den_q [2];
	logic [DIV_D_W-1:0] rem_q [2];
	logic [DIV_N_W-1:0] quo_q [2];
	logic [4:0]         div_cnt_q;
	logic [DIV_D_W:0]   rtry [2];

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			rtry[k] = {rem_q[k], num_q[k][DIV_N_W-1]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			lz_q    <= item.level_z;
			empty_q <= !lz_ok || (lvl_first_q[lz_sel] > lvl_last_q[lz_sel]);
			ctr_q   <= lvl_first_q[lz_sel][CIDX_W-1:0];
			last_q  <= lvl_last_q[lz_sel][CIDX_W-1:0];
			wxy_q   <= 22'(wx) * 22'(wy);
			num_q[0] <= (DIV_N_W'({item.point_x, 1'b1}) << 16) + DIV_N_W'(gx);
			num_q[1] <= (DIV_N_W'({item.point_y, 1'b1}) << 16) + DIV_N_W'(gy);
			den_q[0] <= {gx, 1'b0};
			den_q[1] <= {gy, 1'b0};
			rem_q[0] <= '0;
			rem_q[1] <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			for (int k = 0; k < 2; k++) begin
				num_q[k] <= num_q[k] << 1;
				if (rtry[k] >= {1'b0, den_q[k]}) begin
					rem_q[k] <= DIV_D_W'(rtry[k] - {1'b0, den_q[k]});
					quo_q[k] <= {quo_q[k][DIV_N_W-2:0], 1'b1};
				end else begin
					rem_q[k] <= rtry[k][DIV_D_W-1:0];
					quo_q[k] <= {quo_q[k][DIV_N_W-2:0], 1'b0};
				end
			end
			div_cnt_q <= div_cnt_q + 5'd1;
		end else if (cmd.acc) begin
			ctr_q <= ctr_q + CIDX_W'(1);
		end
	end

	// per-center term
	logic [COORD_W-1:0] cx, cy;
	logic signed [DIV_N_W:0] ddx, ddy;
	logic [DIV_N_W-1:0] adx_q, ady_q;
	logic [27:0]        tx_q, ty_q;
	logic [53:0]        sqx_q, sqy_q;
	logic [11:0]        dx_q, dy_q;
	logic [54:0]        d2_q;
	logic [22:0]        dyw_q;
	logic [46:0]        phi_q;
	logic [55:0]        plo_q;
	logic [47:0]        arg_c;
	logic [22:0]        lzoff;
	logic [EXP_STEPS-1:0] arg_q;
	logic               big_q;
	logic               term_flt_q;
	logic [30:0]        e_q;
	logic [4:0]         b_q;
	logic [60:0]        eprod;
	logic [16:0]        g_c;
	logic [WGT_W-1:0]   w_c;
	logic signed [49:0] prod_q;
	logic signed [55:0] acc_q;
	logic               fault_q;

	assign cx  = cen_rd_q[COORD_W-1:0];
	assign cy  = cen_rd_q[2*COORD_W-1:COORD_W];
	assign ddx = $signed({1'b0, quo_q[0]}) - $signed((DIV_N_W+1)'(cx));
	assign ddy = $signed({1'b0, quo_q[1]}) - $signed((DIV_N_W+1)'(cy));

	assign arg_c = 48'(phi_q) + 48'(plo_q[55:32]);
	assign lzoff = (lz_q == 2'd2) ? {wxy_q, 1'b0} : (lz_q == 2'd1) ? {1'b0, wxy_q} : '0;
	assign idx_c = 25'(dx_q) + 25'(dyw_q) + 25'(lzoff);
	assign idx_flt = (idx_c >= 25'(WEIGHT_DEPTH));

	assign eprod = 61'(e_q) * 61'(exp_bit(b_q)) + (61'(1) << 29);
	assign g_c   = big_q ? '0 : 17'((31'(e_q) + 31'd8192) >> 14);
	assign w_c   = term_flt_q ? '0 : wgt_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.sub) begin
			adx_q <= ddx[DIV_N_W] ? DIV_N_W'(-ddx) : ddx[DIV_N_W-1:0];
			ady_q <= ddy[DIV_N_W] ? DIV_N_W'(-ddy) : ddy[DIV_N_W-1:0];
			tx_q  <= 28'(cx) * 28'(wx);
			ty_q  <= 28'(cy) * 28'(wy);
		end
		if (cmd.sq) begin
			sqx_q <= 54'(adx_q) * 54'(adx_q);
			sqy_q <= 54'(ady_q) * 54'(ady_q);
			// truncation of c*size - 0.5
			dx_q  <= (tx_q >= 28'd32768) ? 12'((tx_q - 28'd32768) >> 16) : '0;
			dy_q  <= (ty_q >= 28'd32768) ? 12'((ty_q - 28'd32768) >> 16) : '0;
		end
		if (cmd.sum) begin
			d2_q  <= 55'(sqx_q) + 55'(sqy_q);
			dyw_q <= 23'(dy_q) * 23'(wx);
		end
		if (cmd.mul) begin
			phi_q <= 47'(d2_q[54:32]) * 47'(cfg.inv_sigma_sq);
			plo_q <= 56'(d2_q[31:0]) * 56'(cfg.inv_sigma_sq);
		end
		if (cmd.idx) begin
			arg_q      <= arg_c[EXP_STEPS-1:0];
			big_q      <= |arg_c[47:EXP_STEPS];
			term_flt_q <= idx_flt;
			e_q        <= 31'(1) << 30;
			b_q        <= '0;
		end else if (cmd.exp_step) begin
			if (arg_q[b_q]) begin
				e_q <= 31'(eprod >> 30);
			end
			b_q <= b_q + 5'd1;
		end
		if (cmd.gmul) begin
			prod_q <= 50'($signed(w_c) * $signed({1'b0, g_c}));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			fault_q <= 1'b0;
		end else if (cmd.start) begin
			acc_q   <= '0;
			fault_q <= 1'b0;
		end else begin
			if (cmd.idx && idx_flt) begin
				fault_q <= 1'b1;
			end
			if (cmd.acc) begin
				acc_q <= acc_q + 56'(prod_q);
			end
		end
	end

	// round half up to Q.16; 64 terms cannot reach the 48-bit limits
	logic signed [56:0] rnd;
	assign rnd       = 57'(acc_q) + 57'sd32768;
	assign res_sum   = {{(SUM_W-41){rnd[56]}}, rnd[56:16]};
	assign res_fault = fault_q;

	assign sts.div_done    = (div_cnt_q == 5'(DIV_N_W - 1));
	assign sts.empty       = empty_q;
	assign sts.exp_done    = (b_q == 5'(EXP_STEPS - 1));
	assign sts.last_center = (ctr_q == last_q);

endmodule

[hw/rtl/gaussian_rbf_grid_eval.sv]
// Top level of the Gaussian RBF grid evaluator: config registers, result register, sequencer, datapath.
//
//  channel   dir  beat fields
//  s_*       in   tuser: kind; tdata: slot_index..point_y
//  m_*       out  tuser: index_fault; tdata: sum_value
//  cfg_*     in   write-only register port, index = register number
//
// Loads are written while idle and leave the sequencer idle. A query runs the
// coordinate divider, then per center in its level's slot range: read, subtract,
// square, sum, scale, index, exp multiply chain, weight multiply and accumulate.
// Reset clears config to defaults and empties all level ranges; stores are not cleared.
// A finished result waits in the output register while the next beat is taken;
// a query stalls only at its end if that register is still full.
module gaussian_rbf_grid_eval
	import grbf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // slot_index, center_x, center_y, level_z,
	                                         // weight_value, point_x, point_y, zero pad
	input  logic [1:0]            s_tuser,   // kind
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // sum_value
	output logic                  m_tuser,   // index_fault
	input  logic                  cfg_wr_en,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [INV_W-1:0]      cfg_wdata
);

	cfg_t  cfg_q;
	cmd_t  cmd;
	sts_t  sts;
	item_t item;
	kind_t kind;
	logic  out_free;
	logic [SUM_W-1:0] res_sum;
	logic  res_fault;
	logic  m_valid_q;
	logic [SUM_W-1:0] m_sum_q;
	logic  m_fault_q;

	assign item = item_t'(s_tdata[$bits(item_t)-1:0]);
	assign kind = kind_t'(s_tuser);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_x_size   <= SIZE_W'(16);
			cfg_q.grid_y_size   <= SIZE_W'(16);
			cfg_q.weight_x_size <= SIZE_W'(8);
			cfg_q.weight_y_size <= SIZE_W'(8);
			cfg_q.inv_sigma_sq  <= INV_W'(65536);
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_GRID_X:   cfg_q.grid_x_size   <= cfg_wdata[SIZE_W-1:0];
				REG_GRID_Y:   cfg_q.grid_y_size   <= cfg_wdata[SIZE_W-1:0];
				REG_WEIGHT_X: cfg_q.weight_x_size <= cfg_wdata[SIZE_W-1:0];
				REG_WEIGHT_Y: cfg_q.weight_y_size <= cfg_wdata[SIZE_W-1:0];
				REG_INV_SIG:  cfg_q.inv_sigma_sq  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign out_free = !m_valid_q || m_tready;

	grbf_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_is_query (kind == KIND_QUERY),
		.sts         (sts),
		.out_free    (out_free),
		.in_ready    (s_tready),
		.cmd         (cmd)
	);

	grbf_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.kind      (kind),
		.item      (item),
		.cfg       (cfg_q),
		.sts       (sts),
		.res_sum   (res_sum),
		.res_fault (res_fault)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.push) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			m_sum_q   <= res_sum;
			m_fault_q <= res_fault;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_sum_q;
	assign m_tuser  = m_fault_q;

	a_query_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && kind == KIND_QUERY) |=> !s_tready)
		else $error("input taken while a query is in flight");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!m_valid_q || m_tready))
		else $error("result pushed over an unread beat");

	a_push_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !s_tready)
		else $error("result pushed with sequencer idle");

endmodule
